[hdl/ucf_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 safe content line folder package
// Shared item type and octet constants for the content line folder.
// ----------------------------------------------------------------------------
package ucf_pkg;

  // Octets of the fold and line terminator sequences.
  localparam logic [7:0] OCTET_CR = 8'd13;
  localparam logic [7:0] OCTET_LF = 8'd10;
  localparam logic [7:0] OCTET_SP = 8'd32;

  // A continuation octet matches 10xxxxxx.
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Reset value of the chunk length register.
  localparam logic [7:0] CHUNK_RESET = 8'd74;

  // One input request: an octet and the end-of-line mark.
  typedef struct packed {
    logic       line_end;
    logic [7:0] data_byte;
  } ucf_item_t;

endpackage

[hdl/ucf_in_reg.sv]
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted input request until the folding core takes it.
// ----------------------------------------------------------------------------
module ucf_in_reg
  import ucf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  ucf_item_t in_item_i,
  output logic      in_ready_o,
  output logic      item_valid_o,
  output ucf_item_t item_o,
  input  logic      take_i
);

  logic      valid_q;
  ucf_item_t item_q;

  // The register is free when empty or when its content leaves this cycle.
  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

[hdl/ucf_fold_core.sv]
// ----------------------------------------------------------------------------
// Folding core
// Groups octets into characters, tracks the column and builds the octet
// sequence that one input request causes, including folds and terminator.
// ----------------------------------------------------------------------------
module ucf_fold_core
  import ucf_pkg::*;
#(
  parameter int MAX_CHAR_BYTES = 4,
  localparam int SEQ_LEN = MAX_CHAR_BYTES + 9,
  localparam int SEQ_W   = $clog2(SEQ_LEN + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [7:0]       cfg_wr_data_i,
  input  logic             item_valid_i,
  input  ucf_item_t        item_i,
  input  logic             seq_free_i,
  output logic             take_o,
  output logic [7:0]       seq_o [SEQ_LEN],
  output logic [SEQ_W-1:0] seq_cnt_o
);

  localparam int CNT_W  = $clog2(MAX_CHAR_BYTES + 1);
  localparam int HIDX_W = $clog2(MAX_CHAR_BYTES);
  localparam int IDX_W  = $clog2(SEQ_LEN);

  logic [7:0]       chunk_q;
  logic [7:0]       col_q, col_d, col1;
  logic [CNT_W-1:0] held_cnt_q, held_cnt_d, cnt2;
  logic [7:0]       held_q [MAX_CHAR_BYTES];
  logic [7:0]       held_d [MAX_CHAR_BYTES];
  logic             cont, app, flush1, fold1, fold2;
  logic [SEQ_W-1:0] pos;

  assign take_o = item_valid_i && seq_free_i;

  // Character grouping, column tracking and sequence assembly.
  always_comb begin
    cont   = (item_i.data_byte & CONT_MASK) == CONT_TAG;
    app    = cont && (held_cnt_q != '0) && (held_cnt_q < CNT_W'(MAX_CHAR_BYTES));
    flush1 = !app && (held_cnt_q != '0);
    fold1  = flush1 && (col_q != 8'd0) &&
             (({1'b0, col_q} + 9'(held_cnt_q)) > {1'b0, chunk_q});
    col1   = flush1 ? ((fold1 ? 8'd0 : col_q) + 8'(held_cnt_q)) : col_q;

    held_d = held_q;
    if (app) begin
      held_d[held_cnt_q[HIDX_W-1:0]] = item_i.data_byte;
      cnt2 = held_cnt_q + CNT_W'(1);
    end else begin
      held_d[0] = item_i.data_byte;
      cnt2 = CNT_W'(1);
    end

    fold2 = item_i.line_end && (col1 != 8'd0) &&
            (({1'b0, col1} + 9'(cnt2)) > {1'b0, chunk_q});

    seq_o = '{default: 8'h00};
    pos   = '0;
    // Fold before the flushed character.
    if (fold1) begin
      seq_o[pos[IDX_W-1:0]]               = OCTET_CR;
      seq_o[IDX_W'(pos + SEQ_W'(1))]      = OCTET_LF;
      seq_o[IDX_W'(pos + SEQ_W'(2))]      = OCTET_SP;
      pos = pos + SEQ_W'(3);
    end
    // The held character, when the new octet starts another one.
    if (flush1) begin
      for (int i = 0; i < MAX_CHAR_BYTES; i++) begin
        if (CNT_W'(i) < held_cnt_q) begin
          seq_o[IDX_W'(pos + SEQ_W'(i))] = held_q[i];
        end
      end
      pos = pos + SEQ_W'(held_cnt_q);
    end
    // At the end of the line the last character and CR LF follow.
    if (item_i.line_end) begin
      if (fold2) begin
        seq_o[pos[IDX_W-1:0]]          = OCTET_CR;
        seq_o[IDX_W'(pos + SEQ_W'(1))] = OCTET_LF;
        seq_o[IDX_W'(pos + SEQ_W'(2))] = OCTET_SP;
        pos = pos + SEQ_W'(3);
      end
      for (int i = 0; i < MAX_CHAR_BYTES; i++) begin
        if (CNT_W'(i) < cnt2) begin
          seq_o[IDX_W'(pos + SEQ_W'(i))] = held_d[i];
        end
      end
      pos = pos + SEQ_W'(cnt2);
      seq_o[pos[IDX_W-1:0]]          = OCTET_CR;
      seq_o[IDX_W'(pos + SEQ_W'(1))] = OCTET_LF;
      pos = pos + SEQ_W'(2);
    end
    seq_cnt_o = pos;

    col_d      = item_i.line_end ? 8'd0 : col1;
    held_cnt_d = item_i.line_end ? '0 : cnt2;
  end

  // Control state and the chunk length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q    <= CHUNK_RESET;
      col_q      <= 8'd0;
      held_cnt_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        chunk_q <= cfg_wr_data_i;
      end
      if (take_o) begin
        col_q      <= col_d;
        held_cnt_q <= held_cnt_d;
      end
    end
  end

  // Octets of the character being assembled.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      held_q <= held_d;
    end
  end

  // The held character never grows beyond its maximum length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= CNT_W'(MAX_CHAR_BYTES))
    else $error("held character longer than allowed");

  // A line end leaves column and held character cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && item_i.line_end) |=> (col_q == 8'd0 && held_cnt_q == '0))
    else $error("state not cleared after line end");

endmodule

[hdl/ucf_out_seq.sv]
// ----------------------------------------------------------------------------
// Output sequencer
// Holds one request's octet sequence; sends one octet per cycle while ready.
// ----------------------------------------------------------------------------
module ucf_out_seq
  import ucf_pkg::*;
#(
  parameter int SEQ_LEN = 13,
  localparam int SEQ_W  = $clog2(SEQ_LEN + 1),
  localparam int IDX_W  = $clog2(SEQ_LEN)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [7:0]       seq_i [SEQ_LEN],
  input  logic [SEQ_W-1:0] cnt_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  logic [7:0]       buf_q [SEQ_LEN];
  logic [SEQ_W-1:0] cnt_q;
  logic [IDX_W-1:0] rd_q;
  logic             busy_q;
  logic             at_last;

  assign at_last     = busy_q && ((SEQ_W'(rd_q) + SEQ_W'(1)) == cnt_q);
  assign free_o      = !busy_q || (out_ready_i && at_last);
  assign out_valid_o = busy_q;
  assign out_byte_o  = buf_q[rd_q];
  assign out_last_o  = at_last;

  // Read pointer and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else if (load_i) begin
      busy_q <= (cnt_i != '0);
      rd_q   <= '0;
      cnt_q  <= cnt_i;
    end else if (busy_q && out_ready_i) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        rd_q <= rd_q + IDX_W'(1);
      end
    end
  end

  // Sequence octets.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= seq_i;
    end
  end

  // The read pointer stays inside the loaded sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (SEQ_W'(rd_q) < cnt_q))
    else $error("read pointer beyond sequence");

  // A new sequence is loaded only when the previous one is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("sequence overwritten while sending");

  // After the final octet goes out the sequencer is busy only on a new load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_o) |=>
      (busy_q == $past(load_i && (cnt_i != '0))))
    else $error("busy state wrong after final octet");

endmodule

[hdl/utf8_safe_content_line_folder.sv]
// ----------------------------------------------------------------------------
// UTF-8 safe content line folder
// Folds a content line with CR LF SP without splitting UTF-8 characters.
// ----------------------------------------------------------------------------
// The folder takes one octet per request and sends out the folded line one
// octet per cycle while the output is ready. A request waits in the input
// register until the folding core takes it, and the octets it causes are then
// registered in the output sequencer. A continuation octet usually causes
// nothing, and any other octet releases the character held before it. A
// completed character leaves with up to MAX_CHAR_BYTES octets, and a fold adds
// three. The final octet of a line adds its character, a possible fold and CR
// LF. One request can therefore cause up to MAX_CHAR_BYTES + 9 octets. A
// request occupies the output until it has sent all octets it causes, and a
// request that emits nothing does not occupy it. The next request is taken in
// the cycle in which the previous sequence sends its last octet, so the output
// port sets the rate. The input ready depends combinationally on the output
// ready. The chunk length register resets to 74 and should be written only
// while idle.
// ----------------------------------------------------------------------------
module utf8_safe_content_line_folder
  import ucf_pkg::*;
#(
  parameter int MAX_CHAR_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Chunk length register.
  input  logic       cfg_wr_en_i,
  input  logic [7:0] cfg_wr_data_i,
  // Input stream.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // line_end
  // Output stream.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // out_last
);

  localparam int SEQ_LEN = MAX_CHAR_BYTES + 9;
  localparam int SEQ_W   = $clog2(SEQ_LEN + 1);

  ucf_item_t        in_item, item;
  logic             item_valid, take, seq_free;
  logic [7:0]       seq [SEQ_LEN];
  logic [SEQ_W-1:0] seq_cnt;

  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.line_end  = s_axis_tlast_i;

  ucf_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_item_i    (in_item),
    .in_ready_o   (s_axis_tready_o),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  ucf_fold_core #(
    .MAX_CHAR_BYTES (MAX_CHAR_BYTES)
  ) u_fold_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .seq_free_i    (seq_free),
    .take_o        (take),
    .seq_o         (seq),
    .seq_cnt_o     (seq_cnt)
  );

  ucf_out_seq #(
    .SEQ_LEN (SEQ_LEN)
  ) u_out_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .seq_i       (seq),
    .cnt_i       (seq_cnt),
    .free_o      (seq_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
